// ----- src/srdt_pkg.sv -----
package srdt_pkg;

    // table geometry
    localparam int MAX_ENTRIES = 32;
    localparam int NAME_BYTES  = 32;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int LEN_W       = $clog2(NAME_BYTES + 1);

    // record layout
    localparam int ADDR_W     = 48;
    localparam int NAME_LANES = 32;
    localparam int NAME_W     = NAME_LANES * 8;
    localparam int KEY_W      = ADDR_W + NAME_W;
    localparam int ATTR_W     = 24;

    // function codes
    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    // outcome codes
    localparam logic [2:0] OUT_CLEARED  = 3'd0;
    localparam logic [2:0] OUT_APPENDED = 3'd1;
    localparam logic [2:0] OUT_UPDATED  = 3'd2;
    localparam logic [2:0] OUT_KEPT     = 3'd3;
    localparam logic [2:0] OUT_DROPPED  = 3'd4;
    localparam logic [2:0] OUT_READ_OK  = 3'd5;
    localparam logic [2:0] OUT_READ_OOR = 3'd6;

    // comparator verdict for one stored entry
    typedef struct packed {
        logic hit;
        logic stronger;
    } t_cmp_res;

endpackage

// ----- src/srdt_ram.sv -----
module srdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                        i_clk,
    input  logic                                        i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                            i_wr_data,
    input  logic                                        i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/srdt_cmp.sv -----
module srdt_cmp (
    input  logic [srdt_pkg::ADDR_W-1:0] i_key_addr,
    input  logic [srdt_pkg::NAME_W-1:0] i_key_name,
    input  logic [srdt_pkg::LEN_W-1:0]  i_key_len,
    input  logic signed [7:0]           i_key_sig,
    input  logic [srdt_pkg::ADDR_W-1:0] i_ent_addr,
    input  logic [srdt_pkg::NAME_W-1:0] i_ent_name,
    input  logic signed [7:0]           i_ent_sig,
    output srdt_pkg::t_cmp_res          o_res
);
    import srdt_pkg::*;

    logic [NAME_LANES-1:0] lane_ok;

    // per byte: equal inside the key length, zero at the terminator position
    always_comb begin
        for (int k = 0; k < NAME_LANES; k++) begin
            lane_ok[k] = ((LEN_W'(k) >= i_key_len)
                          || (i_ent_name[8*k +: 8] == i_key_name[8*k +: 8]))
                      && ((LEN_W'(k) != i_key_len) || (i_ent_name[8*k +: 8] == 8'd0));
        end
    end

    assign o_res.hit      = (i_ent_addr == i_key_addr) && (&lane_ok);
    assign o_res.stronger = i_key_sig > i_ent_sig;

endmodule

// ----- src/scan_record_dedup_table.sv -----
// Deduplicating table of access point scan records, up to MAX_ENTRIES (32)
// entries. One beat in, one beat out (func 3 is swallowed with no result).
// Insert clamps the name length to 32 bytes, then walks the valid entries
// lowest index first through a single comparator fed by the entry RAM read
// port, one entry per cycle. The first entry with the same station address,
// equal name bytes up to the length and a zero byte at the length is the
// match: its signal, security mode and channel are rewritten only if the new
// signal is strictly stronger. No match appends the zero-padded record, or
// drops it if the table is full. Clear resets the count; read returns the
// entry at read_slot if it is below the count.
// An insert holds the input side through its walk of the RAM read port and its
// done state; clear and read hold it through their done state only.
// A finished item waits in its done state, input side still held, while the
// previous result sits unaccepted in the output register. Entry RAMs are not
// cleared; only entries below the count are ever read, so there is no
// clearing pass after reset.
module scan_record_dedup_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_func,
    input  logic [srdt_pkg::ADDR_W-1:0]   i_station_addr,
    input  logic [7:0]                    i_name_length,
    input  logic [63:0]                   i_name_bytes_0_7,
    input  logic [63:0]                   i_name_bytes_8_15,
    input  logic [63:0]                   i_name_bytes_16_23,
    input  logic [63:0]                   i_name_bytes_24_31,
    input  logic signed [7:0]             i_signal_dbm,
    input  logic [7:0]                    i_security_mode,
    input  logic [7:0]                    i_radio_channel,
    input  logic [4:0]                    i_read_slot,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [2:0]                    o_outcome,
    output logic [4:0]                    o_slot_index,
    output logic [5:0]                    o_entry_count,
    output logic [srdt_pkg::ADDR_W-1:0]   o_out_station_addr,
    output logic [63:0]                   o_out_name_0_7,
    output logic [63:0]                   o_out_name_8_15,
    output logic [63:0]                   o_out_name_16_23,
    output logic [63:0]                   o_out_name_24_31,
    output logic signed [7:0]             o_out_signal_dbm,
    output logic [7:0]                    o_out_security_mode,
    output logic [7:0]                    o_out_channel
);
    import srdt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // control state
    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;         // next entry to fetch
    logic [IDX_W-1:0] r_cidx, n_cidx;       // entry now on the RAM output
    logic             r_cmp_vld, n_cmp_vld;
    logic [2:0]       r_outcome, n_outcome;
    logic [IDX_W-1:0] r_slot, n_slot;
    logic             r_ovld;

    // captured insert record
    logic [ADDR_W-1:0] r_addr;
    logic [NAME_W-1:0] r_name;
    logic [LEN_W-1:0]  r_len;
    logic signed [7:0] r_sig;
    logic [7:0]        r_sec;
    logic [7:0]        r_chn;

    // output beat register
    logic [2:0]        r_o_outcome;
    logic [4:0]        r_o_slot;
    logic [5:0]        r_o_count;
    logic [ADDR_W-1:0] r_o_addr;
    logic [NAME_W-1:0] r_o_name;
    logic [7:0]        r_o_sig;
    logic [7:0]        r_o_sec;
    logic [7:0]        r_o_chn;

    logic              in_acc;
    logic              out_free;
    logic [LEN_W-1:0]  len_clamp;
    logic [NAME_W-1:0] name_in;
    logic [NAME_W-1:0] name_masked;

    // entry RAM ports
    logic              key_we;
    logic              attr_we;
    logic [IDX_W-1:0]  wr_addr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [KEY_W-1:0]  key_rd;
    logic [ATTR_W-1:0] attr_rd;
    t_cmp_res          cmp;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_ovld || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    assign name_in = {i_name_bytes_24_31, i_name_bytes_16_23,
                      i_name_bytes_8_15, i_name_bytes_0_7};
    assign len_clamp = (i_name_length > 8'(NAME_BYTES)) ? LEN_W'(NAME_BYTES)
                                                        : LEN_W'(i_name_length);

    // zero-pad the name past its clamped length
    always_comb begin
        for (int k = 0; k < NAME_LANES; k++) begin
            name_masked[8*k +: 8] = (LEN_W'(k) < len_clamp) ? name_in[8*k +: 8] : 8'd0;
        end
    end

    // key RAM: {station address, name}; attribute RAM: {channel, security, signal}
    srdt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (key_we),
        .i_wr_addr (wr_addr),
        .i_wr_data ({r_addr, r_name}),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (key_rd)
    );

    srdt_ram #(
        .WIDTH (ATTR_W),
        .DEPTH (MAX_ENTRIES)
    ) u_attr_ram (
        .i_clk     (i_clk),
        .i_wr_en   (attr_we),
        .i_wr_addr (wr_addr),
        .i_wr_data ({r_chn, r_sec, r_sig}),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (attr_rd)
    );

    srdt_cmp u_cmp (
        .i_key_addr (r_addr),
        .i_key_name (r_name),
        .i_key_len  (r_len),
        .i_key_sig  (r_sig),
        .i_ent_addr (key_rd[KEY_W-1 -: ADDR_W]),
        .i_ent_name (key_rd[NAME_W-1:0]),
        .i_ent_sig  ($signed(attr_rd[7:0])),
        .o_res      (cmp)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_cidx    = r_cidx;
        n_cmp_vld = r_cmp_vld;
        n_outcome = r_outcome;
        n_slot    = r_slot;
        key_we    = 1'b0;
        attr_we   = 1'b0;
        wr_addr   = r_count[IDX_W-1:0];
        rd_en     = 1'b0;
        rd_addr   = r_idx[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_func)
                        FUNC_CLEAR: begin
                            n_count   = '0;
                            n_outcome = OUT_CLEARED;
                            n_slot    = '0;
                            n_state   = S_DONE;
                        end
                        FUNC_INSERT: begin
                            n_idx     = '0;
                            n_cmp_vld = 1'b0;
                            n_state   = S_SCAN;
                        end
                        FUNC_READ: begin
                            if (CNT_W'(i_read_slot) < r_count) begin
                                rd_en     = 1'b1;
                                rd_addr   = IDX_W'(i_read_slot);
                                n_outcome = OUT_READ_OK;
                                n_slot    = IDX_W'(i_read_slot);
                            end else begin
                                n_outcome = OUT_READ_OOR;
                                n_slot    = '0;
                            end
                            n_state = S_DONE;
                        end
                        default: begin
                            // unused code: beat consumed, no result
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_cmp_vld && cmp.hit) begin
                    n_slot  = r_cidx;
                    n_state = S_DONE;
                    if (cmp.stronger) begin
                        attr_we   = 1'b1;
                        wr_addr   = r_cidx;
                        n_outcome = OUT_UPDATED;
                    end else begin
                        n_outcome = OUT_KEPT;
                    end
                end else if (r_idx == r_count) begin
                    // every valid entry checked, no match
                    n_state = S_DONE;
                    if (r_count >= CNT_W'(MAX_ENTRIES)) begin
                        n_outcome = OUT_DROPPED;
                        n_slot    = '0;
                    end else begin
                        key_we    = 1'b1;
                        attr_we   = 1'b1;
                        n_slot    = r_count[IDX_W-1:0];
                        n_count   = CNT_W'(r_count + 1'b1);
                        n_outcome = OUT_APPENDED;
                    end
                end else begin
                    rd_en     = 1'b1;
                    n_cidx    = r_idx[IDX_W-1:0];
                    n_idx     = CNT_W'(r_idx + 1'b1);
                    n_cmp_vld = 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_cidx    <= '0;
            r_cmp_vld <= 1'b0;
            r_outcome <= OUT_CLEARED;
            r_slot    <= '0;
            r_ovld    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_cidx    <= n_cidx;
            r_cmp_vld <= n_cmp_vld;
            r_outcome <= n_outcome;
            r_slot    <= n_slot;
            if (r_state == S_DONE && out_free) begin
                r_ovld <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // payload capture, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_addr <= i_station_addr;
            r_name <= name_masked;
            r_len  <= len_clamp;
            r_sig  <= i_signal_dbm;
            r_sec  <= i_security_mode;
            r_chn  <= i_radio_channel;
        end
        if (r_state == S_DONE && out_free) begin
            r_o_outcome <= r_outcome;
            r_o_slot    <= 5'(r_slot);
            r_o_count   <= 6'(r_count);
            if (r_outcome == OUT_READ_OK) begin
                r_o_addr <= key_rd[KEY_W-1 -: ADDR_W];
                r_o_name <= key_rd[NAME_W-1:0];
                r_o_sig  <= attr_rd[7:0];
                r_o_sec  <= attr_rd[15:8];
                r_o_chn  <= attr_rd[23:16];
            end else begin
                r_o_addr <= '0;
                r_o_name <= '0;
                r_o_sig  <= '0;
                r_o_sec  <= '0;
                r_o_chn  <= '0;
            end
        end
    end

    assign o_out_valid         = r_ovld;
    assign o_outcome           = r_o_outcome;
    assign o_slot_index        = r_o_slot;
    assign o_entry_count       = r_o_count;
    assign o_out_station_addr  = r_o_addr;
    assign o_out_name_0_7      = r_o_name[63:0];
    assign o_out_name_8_15     = r_o_name[127:64];
    assign o_out_name_16_23    = r_o_name[191:128];
    assign o_out_name_24_31    = r_o_name[255:192];
    assign o_out_signal_dbm    = $signed(r_o_sig);
    assign o_out_security_mode = r_o_sec;
    assign o_out_channel       = r_o_chn;

`ifndef ASSERT_OFF
    // table never holds more than its capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above capacity");

    // count only grows by one or drops to zero
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == CNT_W'($past(r_count) + 1'b1)) || (r_count == '0))
        else $error("entry count jumped");

    // append only into a free slot
    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        key_we |-> (r_count < CNT_W'(MAX_ENTRIES)) && (r_state == S_SCAN))
        else $error("append with table full");

    // a new result beat comes only out of the done state
    a_beat_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result beat without finished item");
`endif

endmodule
